[src/md5_name_uuid_generator_unit_macros.svh]
// assertion macros for the md5 name uuid unit
`ifndef MD5_NAME_UUID_GENERATOR_UNIT_MACROS_SVH
`define MD5_NAME_UUID_GENERATOR_UNIT_MACROS_SVH

// checked only while out of reset
`define MD5UUID_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("md5uuid assertion failed");

// checked during reset too
`define MD5UUID_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("md5uuid reset assertion failed");

`endif

[src/md5uuid_pkg.sv]
// ----------------------------------------------------------------------------
// md5uuid_pkg
// shared types, constants and round tables of the md5 name uuid unit
// ----------------------------------------------------------------------------
package md5uuid_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [7:0] VER_MASK  = 8'h0f;
  localparam logic [7:0] VER_BITS  = 8'h30;
  localparam logic [7:0] VAR_MASK  = 8'h3f;
  localparam logic [7:0] VAR_BITS  = 8'h80;

  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic      put;
    byte_sel_t sel;
    logic      count;
    logic      step;
    logic      add;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
  } dp_sts_t;

  function automatic logic [31:0] round_add(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

[src/md5uuid_dp.sv]
// ----------------------------------------------------------------------------
// md5uuid_dp
// block store, length counter, md5 round unit, chaining state and result
// ----------------------------------------------------------------------------
module md5uuid_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  md5uuid_pkg::dp_cmd_t cmd,
  input  logic [7:0]           data_byte,
  output md5uuid_pkg::dp_sts_t sts,
  output logic [127:0]         uuid_word
);
  import md5uuid_pkg::*;

  logic [31:0] blk_r [16];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] ch_r [4];
  logic [127:0] uuid_r;

  logic [7:0]  put_byte;
  logic [31:0] f, t, rot, m;
  logic [3:0]  g;
  logic [4:0]  s;
  logic [7:0]  dig [16];
  logic [127:0] uuid_nxt;

  always_comb begin
    case (cmd.sel)
      SEL_DATA: put_byte = data_byte;
      SEL_PAD:  put_byte = PAD_BYTE;
      SEL_ZERO: put_byte = 8'h00;
      SEL_LEN:  put_byte = bits_r[{fill_r[2:0], 3'b000} +: 8];
      default:  put_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (round_r[5:4])
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        g = round_r[3:0];
      end
      2'd1: begin
        f = (d_r & b_r) | (~d_r & c_r);
        g = 4'(round_r[3:0] * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        g = 4'(round_r[3:0] * 4'd3 + 4'd5);
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        g = 4'(round_r[3:0] * 4'd7);
      end
    endcase
    m   = blk_r[g];
    t   = f + a_r + round_add(round_r) + m;
    s   = rot_amount({round_r[5:4], round_r[1:0]});
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  always_comb begin
    for (int i = 0; i < 16; i++) dig[i] = ch_r[i / 4][(i % 4) * 8 +: 8];
    dig[6] = (dig[6] & VER_MASK) | VER_BITS;
    dig[8] = (dig[8] & VAR_MASK) | VAR_BITS;
    for (int i = 0; i < 8; i++) begin
      uuid_nxt[(7 - i) * 8 +: 8]      = dig[i];
      uuid_nxt[64 + (7 - i) * 8 +: 8] = dig[8 + i];
    end
  end

  always_comb begin
    fill_nxt  = cmd.put ? 6'(fill_r + 6'd1) : fill_r;
    bits_nxt  = cmd.count ? 64'(bits_r + 64'd8) : bits_r;
    round_nxt = cmd.step ? 6'(round_r + 6'd1) : round_r;
    if (cmd.finish) begin
      fill_nxt = '0;
      bits_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      bits_r  <= '0;
      round_r <= '0;
      ch_r[0] <= INIT_A;
      ch_r[1] <= INIT_B;
      ch_r[2] <= INIT_C;
      ch_r[3] <= INIT_D;
    end else begin
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      round_r <= round_nxt;
      if (cmd.add) begin
        ch_r[0] <= ch_r[0] + a_r;
        ch_r[1] <= ch_r[1] + b_r;
        ch_r[2] <= ch_r[2] + c_r;
        ch_r[3] <= ch_r[3] + d_r;
      end else if (cmd.finish) begin
        ch_r[0] <= INIT_A;
        ch_r[1] <= INIT_B;
        ch_r[2] <= INIT_C;
        ch_r[3] <= INIT_D;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      if (fill_r[1:0] == 2'd0) blk_r[fill_r[5:2]] <= {24'h0, put_byte};
      else blk_r[fill_r[5:2]][{fill_r[1:0], 3'b000} +: 8] <= put_byte;
    end
    // block full: load working words for the rounds
    if (cmd.put && fill_r == 6'd63) begin
      a_r <= ch_r[0];
      b_r <= ch_r[1];
      c_r <= ch_r[2];
      d_r <= ch_r[3];
    end else if (cmd.step) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_r + rot;
    end
    if (cmd.finish) uuid_r <= uuid_nxt;
  end

  assign sts.fill       = fill_r;
  assign sts.last_round = (round_r == 6'd63);
  assign uuid_word      = uuid_r;

endmodule

[src/md5uuid_ctrl.sv]
// ----------------------------------------------------------------------------
// md5uuid_ctrl
// sequencer for byte intake, padding, compression and result hand-off
// ----------------------------------------------------------------------------
module md5uuid_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_present,
  input  logic                 in_last,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  md5uuid_pkg::dp_sts_t sts,
  output md5uuid_pkg::dp_cmd_t cmd
);
  import md5uuid_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_ADD, ST_PAD, ST_FIN
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   first_r, first_nxt;
  logic   len_r, len_nxt;
  logic   oval_r, oval_nxt;
  logic   full;

  assign full = (sts.fill == 6'd63);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    first_nxt = first_r;
    len_nxt   = len_r;
    oval_nxt  = oval_r && !out_tready;
    cmd       = '{put: 1'b0, sel: SEL_DATA, count: 1'b0, step: 1'b0,
                  add: 1'b0, finish: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.put   = in_present;
          cmd.count = in_present;
          first_nxt = 1'b1;
          len_nxt   = 1'b0;
          if (in_present && full) begin
            state_nxt = ST_ROUND;
            ret_nxt   = in_last ? ST_PAD : ST_IDLE;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.put = 1'b1;
        if (first_r) begin
          cmd.sel   = SEL_PAD;
          first_nxt = 1'b0;
        end else if (len_r || sts.fill == 6'd56) begin
          cmd.sel = SEL_LEN;
          len_nxt = 1'b1;
        end else begin
          cmd.sel = SEL_ZERO;
        end
        if (full) begin
          state_nxt = ST_ROUND;
          ret_nxt   = (cmd.sel == SEL_LEN) ? ST_FIN : ST_PAD;
        end
      end
      ST_ROUND: begin
        cmd.step = 1'b1;
        if (sts.last_round) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ret_r;
      end
      ST_FIN: begin
        if (!oval_r || out_tready) begin
          cmd.finish = 1'b1;
          oval_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      first_r <= 1'b0;
      len_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = oval_r;

endmodule

[src/md5_name_uuid_generator_unit.sv]
// ----------------------------------------------------------------------------
// md5_name_uuid_generator_unit
// version 3 uuid from an md5 digest of a byte-serial name
// ----------------------------------------------------------------------------
// in_*  : one name byte per word; in_tuser says a byte is present, in_tlast
//         ends the name (an empty last word ends an empty name)
// out_* : one uuid per name, 128 bits, high half in the low 64 bits
// a byte word is written into the block store; the 64th byte of a block starts the
// 64 md5 rounds (one round per cycle on a single round unit) and then the chain add
// the last word adds padding at one byte per cycle plus the rounds and chain add of
// each padded block, then the load of the result register
// the result register holds a uuid while the next name streams in; only the
// final load waits on a stalled receiver
// after reset the chaining state is the md5 initial value and no uuid is held
// ----------------------------------------------------------------------------
module md5_name_uuid_generator_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,  // data_byte
  input  logic         in_tuser,  // byte_present
  input  logic         in_tlast,  // end_of_name
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata  // uuid_low, uuid_high
);
  import md5uuid_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  md5uuid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_present (in_tuser),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  md5uuid_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_tdata),
    .sts       (sts),
    .uuid_word (out_tdata)
  );

endmodule

[src/md5uuid_chk.sv]
// ----------------------------------------------------------------------------
// md5uuid_chk
// port-level checks of the md5 name uuid unit
// ----------------------------------------------------------------------------
`include "md5_name_uuid_generator_unit_macros.svh"

module md5uuid_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  `MD5UUID_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid)
  `MD5UUID_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `MD5UUID_ASSERT(a_version, out_tvalid |-> out_tdata[15:12] == 4'h3)
  `MD5UUID_ASSERT(a_variant, out_tvalid |-> out_tdata[127:126] == 2'b10)

endmodule

bind md5_name_uuid_generator_unit md5uuid_chk u_md5uuid_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
